// ===== hdl/cau_pkg.sv =====
package cau_pkg;

	// command codes carried in the input tuser
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	// placement strategies
	localparam logic [1:0] FIT_FIRST   = 2'd0;
	localparam logic [1:0] FIT_NEXT    = 2'd1;
	localparam logic [1:0] FIT_BEST    = 2'd2;
	localparam logic [1:0] FIT_UNKNOWN = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_FIT_STRATEGY   = 2'd0;
	localparam logic [1:0] REG_UNITS_IN_USE   = 2'd1;
	localparam logic [1:0] REG_FRAGMENT_LIMIT = 2'd2;

	// fixed field widths
	localparam int REQ_W  = 9;
	localparam int LIFE_W = 8;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

endpackage

// ===== hdl/contiguous_unit_allocator.sv =====
// channel | dir | signals                       | transaction
// s_axis  | in  | s_tvalid s_tready s_tdata/user | one command
// m_axis  | out | m_tvalid m_tready m_tdata      | one result per command
// cfg     | in  | cfg_valid cfg_ready index/data | one register write
//
// the store is a ring of MEM_UNITS cells that rotates one unit per cycle past a head
// allocate with nonzero size and lifetime: search rotation, then update rotation
// tick, clear, unknown, empty allocate: one update rotation
// reset clears every cell at once, no clearing pass
// a new command is taken while the previous result still waits on m_tready
module contiguous_unit_allocator #(
	parameter int MEM_UNITS     = 256,
	parameter int LIFETIME_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // request_size[8:0], lifetime[16:9]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // success[0], runs_probed[8:1], start_unit[16:9],
	                              // fragment_total[24:17]
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int LW   = $clog2(MEM_UNITS + 1);
	localparam int AW   = $clog2(MEM_UNITS);
	localparam int CMPW = (LW > cau_pkg::REQ_W) ? LW : cau_pkg::REQ_W;
	localparam int LB   = LIFETIME_BITS;
	localparam int LXW  = (LB > cau_pkg::LIFE_W) ? LB : cau_pkg::LIFE_W;
	localparam logic [LW-1:0] N_L = LW'(MEM_UNITS);

	// configuration registers
	logic [1:0] fit_strategy_q;
	logic [8:0] units_in_use_q;
	logic [8:0] fragment_limit_q;

	// control
	cau_pkg::state_t state_q;
	logic [LW-1:0]   pos_q;
	logic [1:0]      cmd_q;
	logic [1:0]      strat_q;
	logic [8:0]      need_q;
	logic [LB-1:0]   life_q;
	logic [LW-1:0]   n_q;
	logic [LW-1:0]   cur_q;
	logic [AW-1:0]   cursor_q;

	// search results
	logic          fa_q, fb_q;
	logic [LW-1:0] wa_q, wb_q, pa_q, pb_q, best_len_q, frag_q;

	// output register
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	// ring
	logic [LB-1:0] cell_q [MEM_UNITS];
	logic [LB-1:0] tail_in;
	logic [LB-1:0] hv, nv;
	logic          shift_en, clr_store;

	// tracker
	logic          trk_clr, trk_en, trk_free, trk_bnd;
	logic          closed;
	logic [LW-1:0] run_len, run_start;

	// decoded input
	logic          accept;
	logic [8:0]    in_need;
	logic [7:0]    in_life;
	logic [LXW-1:0] life_x, life_max_x, life_sat_x;
	logic [LW-1:0] n_eff;
	logic [CMPW-1:0] u_x;

	logic          at_end;
	logic          next_mode, best_mode;
	logic          found_w;
	logic [LW-1:0] where_w;
	logic [LW:0]   probes_w;
	logic          fits;
	logic          in_fill;
	logic [CMPW:0] nxt;
	logic          out_free;
	logic          succ;
	logic [7:0]    probes8, start8, frag8;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == cau_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_need   = s_tdata[8:0];
	assign in_life   = s_tdata[16:9];
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// lifetime saturates to what a cell holds
	assign life_x     = LXW'(in_life);
	assign life_max_x = LXW'({LB{1'b1}});
	assign life_sat_x = (life_x > life_max_x) ? life_max_x : life_x;

	// managed count clamped to 1..MEM_UNITS
	assign u_x   = CMPW'(units_in_use_q);
	assign n_eff = (units_in_use_q == '0) ? LW'(1) :
	               (u_x > CMPW'(MEM_UNITS)) ? N_L : LW'(units_in_use_q);

	assign at_end    = (pos_q == N_L);
	assign next_mode = (strat_q == cau_pkg::FIT_NEXT);
	assign best_mode = (strat_q == cau_pkg::FIT_BEST);

	// combined search outcome, valid once the search rotation is over
	assign found_w  = fa_q || (next_mode && fb_q);
	assign where_w  = fa_q ? wa_q : wb_q;
	assign probes_w = (LW+1)'(pa_q) + (fa_q ? '0 : (LW+1)'(pb_q));
	assign fits     = CMPW'(run_len) >= CMPW'(need_q);

	// head value and its updated form
	assign hv      = cell_q[0];
	assign in_fill = found_w && (pos_q >= where_w) && (pos_q < n_q) &&
	                 (CMPW'(pos_q - where_w) < CMPW'(need_q));

	always_comb begin
		nv = hv;
		case (cmd_q)
			cau_pkg::CMD_ALLOC: begin
				if (in_fill) begin
					nv = life_q;
				end
			end
			cau_pkg::CMD_TICK: begin
				if ((pos_q < n_q) && (hv != '0)) begin
					nv = hv - LB'(1);
				end
			end
			default: begin
				nv = hv;
			end
		endcase
	end

	assign tail_in   = (state_q == cau_pkg::ST_UPDATE) ? nv : hv;
	assign shift_en  = ((state_q == cau_pkg::ST_SCAN) || (state_q == cau_pkg::ST_UPDATE)) &&
	                   !at_end;
	assign clr_store = accept && (s_tuser == cau_pkg::CMD_CLEAR);

	// tracker feeds: unmodified head during search, new value during update
	assign trk_clr  = accept || ((state_q == cau_pkg::ST_SCAN) && at_end);
	assign trk_en   = (state_q == cau_pkg::ST_SCAN) || (state_q == cau_pkg::ST_UPDATE);
	assign trk_free = !at_end && (pos_q < n_q) &&
	                  (((state_q == cau_pkg::ST_SCAN) && (hv == '0)) ||
	                   ((state_q == cau_pkg::ST_UPDATE) && (nv == '0)));
	// next fit splits the run that crosses the cursor
	assign trk_bnd  = (state_q == cau_pkg::ST_SCAN) && next_mode && !at_end &&
	                  (pos_q == cur_q) && (cur_q != '0);

	genvar g;
	generate
		for (g = 0; g < MEM_UNITS; g++) begin : g_ring
			if (g == MEM_UNITS - 1) begin : g_tail
				cau_cell #(.W(LB)) u_cell (
					.clk   (clk),
					.arst_n(arst_n),
					.clr   (clr_store),
					.shift (shift_en),
					.d     (tail_in),
					.q     (cell_q[g])
				);
			end else begin : g_body
				cau_cell #(.W(LB)) u_cell (
					.clk   (clk),
					.arst_n(arst_n),
					.clr   (clr_store),
					.shift (shift_en),
					.d     (cell_q[g+1]),
					.q     (cell_q[g])
				);
			end
		end
	endgenerate

	cau_run_tracker #(.LW(LW)) u_trk (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (trk_clr),
		.en       (trk_en),
		.free     (trk_free),
		.bnd      (trk_bnd),
		.pos      (pos_q),
		.closed   (closed),
		.run_len  (run_len),
		.run_start(run_start)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_strategy_q   <= cau_pkg::FIT_FIRST;
			units_in_use_q   <= 9'd256;
			fragment_limit_q <= 9'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cau_pkg::REG_FIT_STRATEGY:   fit_strategy_q   <= cfg_data[1:0];
				cau_pkg::REG_UNITS_IN_USE:   units_in_use_q   <= cfg_data;
				cau_pkg::REG_FRAGMENT_LIMIT: fragment_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// result fields
	assign out_free = !m_tvalid_q || m_tready;
	assign succ     = (cmd_q == cau_pkg::CMD_ALLOC) ? found_w :
	                  ((cmd_q == cau_pkg::CMD_TICK) || (cmd_q == cau_pkg::CMD_CLEAR));
	assign probes8  = (probes_w > (LW+1)'(255)) ? 8'd255 : 8'(probes_w);
	assign start8   = found_w ? 8'(where_w) : 8'd0;
	assign frag8    = ((LW+1)'(frag_q) > (LW+1)'(255)) ? 8'd255 : 8'(frag_q);
	assign nxt      = (CMPW+1)'(where_w) + (CMPW+1)'(need_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cau_pkg::ST_IDLE;
			pos_q      <= '0;
			cmd_q      <= cau_pkg::CMD_ALLOC;
			strat_q    <= cau_pkg::FIT_FIRST;
			cursor_q   <= '0;
			fa_q       <= 1'b0;
			fb_q       <= 1'b0;
			pa_q       <= '0;
			pb_q       <= '0;
			frag_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// the result state reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != cau_pkg::ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				cau_pkg::ST_IDLE: begin
					if (accept) begin
						cmd_q   <= s_tuser;
						strat_q <= fit_strategy_q;
						need_q  <= in_need;
						life_q  <= LB'(life_sat_x);
						n_q     <= n_eff;
						cur_q   <= ((fit_strategy_q == cau_pkg::FIT_NEXT) &&
						            (LW'(cursor_q) < n_eff)) ? LW'(cursor_q) : '0;
						pos_q   <= '0;
						fa_q    <= 1'b0;
						fb_q    <= 1'b0;
						pa_q    <= '0;
						pb_q    <= '0;
						frag_q  <= '0;
						if ((s_tuser == cau_pkg::CMD_ALLOC) && (in_need != '0) &&
						    (in_life != '0)) begin
							state_q <= cau_pkg::ST_SCAN;
						end else begin
							state_q <= cau_pkg::ST_UPDATE;
						end
					end
				end
				cau_pkg::ST_SCAN: begin
					if (closed) begin
						if (best_mode) begin
							pa_q <= pa_q + LW'(1);
							if (fits && (!fa_q || (run_len < best_len_q))) begin
								fa_q       <= 1'b1;
								best_len_q <= run_len;
								wa_q       <= run_start;
							end
						end else if (next_mode && (run_start < cur_q)) begin
							if (!fb_q) begin
								pb_q <= pb_q + LW'(1);
								if (fits) begin
									fb_q <= 1'b1;
									wb_q <= run_start;
								end
							end
						end else if (!fa_q) begin
							pa_q <= pa_q + LW'(1);
							if (fits) begin
								fa_q <= 1'b1;
								wa_q <= run_start;
							end
						end
					end
					if (at_end) begin
						pos_q   <= '0;
						state_q <= cau_pkg::ST_UPDATE;
					end else begin
						pos_q <= pos_q + LW'(1);
					end
				end
				cau_pkg::ST_UPDATE: begin
					if (closed && (CMPW'(run_len) <= CMPW'(fragment_limit_q))) begin
						frag_q <= frag_q + LW'(1);
					end
					if (at_end) begin
						state_q <= cau_pkg::ST_DONE;
						if ((cmd_q == cau_pkg::CMD_ALLOC) && next_mode && found_w) begin
							cursor_q <= (nxt >= (CMPW+1)'(n_q)) ? '0 : AW'(nxt);
						end
					end else begin
						pos_q <= pos_q + LW'(1);
					end
				end
				cau_pkg::ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {7'd0, frag8, start8,
						               (cmd_q == cau_pkg::CMD_ALLOC) ? probes8 : 8'd0, succ};
						state_q    <= cau_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= cau_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// ring position never runs past the closing step
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= N_L))
		else $error("ring position out of range");

	// the update rotation ends in the result state
	a_update_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == cau_pkg::ST_UPDATE) && at_end) |=> (state_q == cau_pkg::ST_DONE))
		else $error("update rotation did not finish");

	// only allocate searches
	a_scan_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cau_pkg::ST_SCAN) |-> (cmd_q == cau_pkg::CMD_ALLOC))
		else $error("search without allocate");

	// a failed command reports no start unit
	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tdata_q[0]) |-> (m_tdata_q[16:9] == 8'd0))
		else $error("start unit on failure");

endmodule

// ===== hdl/cau_cell.sv =====
module cau_cell #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clr,
	input  logic         shift,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (clr) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

// ===== hdl/cau_run_tracker.sv =====
module cau_run_tracker #(
	parameter int LW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          en,
	input  logic          free,
	input  logic          bnd,
	input  logic [LW-1:0] pos,
	output logic          closed,
	output logic [LW-1:0] run_len,
	output logic [LW-1:0] run_start
);

	logic [LW-1:0] len_q;
	logic [LW-1:0] start_q;
	logic          open_new;

	// a run closes on a busy unit or at a split point
	assign closed    = (len_q != '0) && (!free || bnd);
	assign open_new  = free && ((len_q == '0) || bnd);
	assign run_len   = len_q;
	assign run_start = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			start_q <= '0;
		end else if (clr) begin
			len_q   <= '0;
			start_q <= '0;
		end else if (en) begin
			if (!free) begin
				len_q <= '0;
			end else if (open_new) begin
				len_q   <= LW'(1);
				start_q <= pos;
			end else begin
				len_q <= len_q + LW'(1);
			end
		end
	end

endmodule
